// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the RTL, clocked on clk
// and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define BTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define BTA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// File: rtl/bta_pkg.sv
// ----------------------------------------------------------------------------
// Buddy tree allocator package
// Tree geometry constants, derived widths, node state codes, command and
// status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

  // Tree geometry.
  localparam int unsigned LEVELS      = 4;
  localparam int unsigned MIN_BLOCK   = 8;
  localparam int unsigned NODES       = (1 << LEVELS) - 1;
  localparam int unsigned TOTAL_UNITS = MIN_BLOCK << (LEVELS - 1);

  // Derived widths.
  localparam int unsigned NODE_W  = (LEVELS > 1) ? $clog2(NODES) : 1;
  localparam int unsigned DEPTH_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SPAN_W  = $clog2(TOTAL_UNITS + 1);

  typedef logic [NODE_W-1:0]  node_idx_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [SPAN_W-1:0]  span_t;

  // State of one tree node.
  typedef enum logic [1:0] {
    NS_EMPTY   = 2'd0,
    NS_SPLIT   = 2'd1,
    NS_FULL    = 2'd2,
    NS_ALLFULL = 2'd3
  } node_state_t;

  // Command codes.
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_UP,
    S_A_C1,
    S_A_C2,
    S_A_C3,
    S_F_RD,
    S_F_EV,
    S_F_UP,
    S_F_P0,
    S_F_P1,
    S_F_P2,
    S_F_P3
  } fsm_t;

endpackage

`default_nettype wire

// File: rtl/buddy_tree_allocator.sv
// Result: the result strobe follows in the cycle after the last step of a command; a
// rejected command (oversize request, address outside the region) has no steps.
// An allocate reads and evaluates each node visited and checks both children of each
// subtree given up. A free walks down the address path, then checks each parent and its
// children on the way up. One command at a time, paced by the registered node read.
// Reset (synchronous, active high) marks all nodes empty.
// ----------------------------------------------------------------------------
// Buddy tree allocator
// Allocates and frees power-of-two blocks from a region by walking a binary
// tree of node states kept in a small synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module buddy_tree_allocator
  import bta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [15:0] request_size,
  input  wire logic [31:0] free_address,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      block_address
);

  // Configuration and sequencer registers.
  logic [31:0] base_address;
  fsm_t        state, state_next;
  node_idx_t   node, node_next;
  depth_t      depth, depth_next;
  depth_t      tgt, tgt_next;
  span_t       span, span_next;
  span_t       blk_start, blk_start_next;
  span_t       off, off_next;
  logic        flag, flag_next;
  node_state_t ps, ps_next;

  // Node memory with per-entry valid bits; an invalid entry reads as empty.
  node_state_t node_mem [NODES];
  logic [NODES-1:0] node_vld;
  node_state_t rd_data;
  logic        rd_en, wr_en;
  node_idx_t   rd_addr, wr_addr;
  node_state_t wr_data;

  // Result of the current transaction.
  logic        fin;
  status_t     fin_status;
  logic [31:0] fin_addr;

  // Request decode.
  logic [31:0] size_eff;
  logic        too_big;
  depth_t      tgt_calc;
  logic [31:0] addr_diff;
  logic        in_range;
  span_t       half;

  function automatic logic is_taken(input node_state_t s);
    is_taken = (s == NS_FULL) || (s == NS_ALLFULL);
  endfunction

  function automatic node_idx_t lo_child(input node_idx_t n);
    lo_child = node_idx_t'({n, 1'b1});
  endfunction

  function automatic node_idx_t hi_child(input node_idx_t n);
    hi_child = node_idx_t'({n, 1'b1}) + node_idx_t'(1);
  endfunction

  function automatic node_idx_t parent_of(input node_idx_t n);
    parent_of = node_idx_t'((n - node_idx_t'(1)) >> 1);
  endfunction

  assign busy = (state != S_IDLE);
  assign half = span >> 1;

  // Size rounding and target level: the deepest level whose blocks still fit.
  always_comb begin
    size_eff = (request_size < 16'(MIN_BLOCK)) ? 32'(MIN_BLOCK) : {16'd0, request_size};
    too_big  = size_eff > 32'(TOTAL_UNITS);
    tgt_calc = '0;
    for (int d = 0; d < LEVELS; d++) begin
      if (size_eff <= (32'(TOTAL_UNITS) >> d)) begin
        tgt_calc = depth_t'(d);
      end
    end
  end

  // Free address range check and offset into the region.
  assign addr_diff = free_address - base_address;
  assign in_range  = (free_address >= base_address) && (addr_diff < 32'(TOTAL_UNITS));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_we) begin
      base_address <= cfg_wdata;
    end
  end

  // Node memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= node_vld[rd_addr] ? node_mem[rd_addr] : NS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_vld <= '0;
    end else if (wr_en) begin
      node_vld[wr_addr] <= 1'b1;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    node      <= node_next;
    depth     <= depth_next;
    tgt       <= tgt_next;
    span      <= span_next;
    blk_start <= blk_start_next;
    off       <= off_next;
    flag      <= flag_next;
    ps        <= ps_next;
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status        <= fin_status;
      block_address <= fin_addr;
    end
  end

  // Next state, memory accesses and results. The sequencer never reads and
  // writes the memory in the same cycle, so a read always sees earlier writes.
  always_comb begin
    state_next     = state;
    node_next      = node;
    depth_next     = depth;
    tgt_next       = tgt;
    span_next      = span;
    blk_start_next = blk_start;
    off_next       = off;
    flag_next      = flag;
    ps_next        = ps;
    rd_en          = 1'b0;
    rd_addr        = node;
    wr_en          = 1'b0;
    wr_addr        = node;
    wr_data        = NS_EMPTY;
    fin            = 1'b0;
    fin_status     = ST_DONE;
    fin_addr       = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          node_next      = '0;
          depth_next     = '0;
          span_next      = span_t'(TOTAL_UNITS);
          blk_start_next = '0;
          if (cmd_t'(command) == CMD_ALLOC) begin
            if (too_big) begin
              fin        = 1'b1;
              fin_status = ST_NO_FIT;
            end else begin
              tgt_next   = tgt_calc;
              state_next = S_A_RD;
            end
          end else begin
            if (!in_range) begin
              fin        = 1'b1;
              fin_status = ST_NOT_ALLOC;
            end else begin
              off_next   = addr_diff[SPAN_W-1:0];
              state_next = S_F_RD;
            end
          end
        end
      end

      // Allocate: read the current node.
      S_A_RD: begin
        rd_en      = 1'b1;
        state_next = S_A_EV;
      end

      // Allocate: take an empty node at the target level, descend into a node that is not taken, or give up.
      S_A_EV: begin
        if (depth == tgt) begin
          if (rd_data == NS_EMPTY) begin
            wr_en      = 1'b1;
            wr_data    = NS_FULL;
            fin        = 1'b1;
            fin_status = ST_DONE;
            fin_addr   = base_address + 32'(blk_start);
            state_next = S_IDLE;
          end else begin
            state_next = S_A_UP;
          end
        end else if (is_taken(rd_data)) begin
          state_next = S_A_UP;
        end else begin
          if (rd_data == NS_EMPTY) begin
            wr_en   = 1'b1;
            wr_data = NS_SPLIT;
          end
          node_next  = lo_child(node);
          depth_next = depth + depth_t'(1);
          span_next  = half;
          state_next = S_A_RD;
        end
      end

      // Allocate: the current subtree failed; try the upper sibling, back up, or report no fit at the root.
      S_A_UP: begin
        if (depth == '0) begin
          fin        = 1'b1;
          fin_status = ST_NO_FIT;
          state_next = S_IDLE;
        end else if (node[0]) begin
          node_next      = node + node_idx_t'(1);
          blk_start_next = blk_start + span;
          state_next     = S_A_RD;
        end else begin
          node_next      = parent_of(node);
          depth_next     = depth - depth_t'(1);
          blk_start_next = blk_start - span;
          span_next      = span_t'(span << 1);
          state_next     = S_A_C1;
        end
      end

      // Allocate: mark a failed parent all-full when both children are taken.
      S_A_C1: begin
        rd_en      = 1'b1;
        rd_addr    = lo_child(node);
        state_next = S_A_C2;
      end

      S_A_C2: begin
        flag_next  = is_taken(rd_data);
        rd_en      = 1'b1;
        rd_addr    = hi_child(node);
        state_next = S_A_C3;
      end

      S_A_C3: begin
        if (flag && is_taken(rd_data)) begin
          wr_en   = 1'b1;
          wr_data = NS_ALLFULL;
        end
        state_next = S_A_UP;
      end

      // Free: read the node on the address path.
      S_F_RD: begin
        rd_en      = 1'b1;
        state_next = S_F_EV;
      end

      // Free: empty the full node, follow the address one level down, or refuse the free at the deepest level.
      S_F_EV: begin
        if (rd_data == NS_FULL) begin
          wr_en      = 1'b1;
          wr_data    = NS_EMPTY;
          state_next = S_F_UP;
        end else if (depth == depth_t'(LEVELS - 1)) begin
          fin        = 1'b1;
          fin_status = ST_NOT_ALLOC;
          state_next = S_IDLE;
        end else begin
          span_next  = half;
          depth_next = depth + depth_t'(1);
          if (off < blk_start + half) begin
            node_next = lo_child(node);
          end else begin
            node_next      = hi_child(node);
            blk_start_next = blk_start + half;
          end
          state_next = S_F_RD;
        end
      end

      // Free: climb to the parent, or finish at the root.
      S_F_UP: begin
        if (depth == '0) begin
          fin        = 1'b1;
          fin_status = ST_DONE;
          state_next = S_IDLE;
        end else begin
          node_next  = parent_of(node);
          depth_next = depth - depth_t'(1);
          state_next = S_F_P0;
        end
      end

      // Free: reopen an all-full parent and merge two empty buddies.
      S_F_P0: begin
        rd_en      = 1'b1;
        state_next = S_F_P1;
      end

      S_F_P1: begin
        ps_next    = rd_data;
        rd_en      = 1'b1;
        rd_addr    = lo_child(node);
        state_next = S_F_P2;
      end

      S_F_P2: begin
        flag_next  = (rd_data == NS_EMPTY);
        rd_en      = 1'b1;
        rd_addr    = hi_child(node);
        state_next = S_F_P3;
      end

      S_F_P3: begin
        wr_en = 1'b1;
        if (flag && (rd_data == NS_EMPTY)) begin
          wr_data = NS_EMPTY;
        end else if (ps == NS_ALLFULL) begin
          wr_data = NS_SPLIT;
        end else begin
          wr_data = ps;
        end
        state_next = S_F_UP;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer.
  `BTA_NEVER(a_rw_overlap, rd_en && wr_en, "node memory read and write in one cycle")
  `BTA_ASSERT(a_wr_busy, wr_en |-> busy, "node memory written while idle")
  `BTA_ASSERT(a_done_src, done |-> $past(busy || start), "result without a transaction")
  `BTA_NEVER(a_fail_zero, done && status != ST_DONE && block_address != '0, "address on failure")
  `BTA_ASSERT(a_accept_moves, (start && !busy) |=> (busy || done), "accepted command stalled")

endmodule

`default_nettype wire

// File: tb/tb_buddy_tree_allocator.sv
// ----------------------------------------------------------------------------
// Buddy tree allocator testbench
// Drives allocate and free commands through the start/busy handshake. The
// commands cover the size and address extremes and all of the block's
// special cases, followed by several phases of random traffic under
// different region base addresses. A scoreboard keeps its own copy of the
// node tree and checks every status and block address against it.
// ----------------------------------------------------------------------------
module tb_buddy_tree_allocator
  import bta_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 134;

  // Tracks the tree of node states and the transactions still in flight.
  class alloc_scoreboard;
    node_state_t node_state[NODES];
    logic [31:0] base_address;
    status_t     status_q[$];
    logic [31:0] block_q[$];
    int          errors;
    int          checked;
    int          granted;
    int          no_fit;
    int          released;
    int          refused;

    function new();
      foreach (node_state[i]) node_state[i] = NS_EMPTY;
      base_address = '0;
    endfunction

    function void set_base(logic [31:0] value);
      base_address = value;
    endfunction

    function bit taken(int unsigned n);
      return node_state[n] == NS_FULL || node_state[n] == NS_ALLFULL;
    endfunction

    // Depth-first search, lower half first, for an empty node at the target depth.
    function bit grab(int unsigned n, int unsigned depth, int unsigned target,
                      longint unsigned lo_off, longint unsigned span,
                      output longint unsigned found_off);
      longint unsigned half;
      int unsigned     lo;
      int unsigned     hi;
      if (depth == target) begin
        if (node_state[n] == NS_EMPTY) begin
          node_state[n] = NS_FULL;
          found_off = lo_off;
          return 1'b1;
        end
        return 1'b0;
      end
      if (taken(n)) return 1'b0;
      if (node_state[n] == NS_EMPTY) node_state[n] = NS_SPLIT;
      half = span >> 1;
      lo   = 2 * n + 1;
      hi   = 2 * n + 2;
      if (grab(lo, depth + 1, target, lo_off, half, found_off)) return 1'b1;
      if (grab(hi, depth + 1, target, lo_off + half, half, found_off)) return 1'b1;
      // A searched node is marked all-full only when both halves are taken.
      if (taken(lo) && taken(hi)) node_state[n] = NS_ALLFULL;
      return 1'b0;
    endfunction

    // Works out the result of an accepted command and queues it.
    function void note_command(cmd_t cmd, logic [15:0] size, logic [31:0] addr);
      status_t         st = ST_DONE;
      logic [31:0]     blk = '0;
      longint unsigned need;
      longint unsigned span;
      longint unsigned lo_off;
      longint unsigned rel;
      int unsigned     target;
      int unsigned     n;
      int unsigned     d;
      int unsigned     p;
      int unsigned     found;
      int unsigned     path[LEVELS];
      if (cmd == CMD_ALLOC) begin
        need = (size < MIN_BLOCK) ? MIN_BLOCK : size;
        if (need > TOTAL_UNITS) begin
          st = ST_NO_FIT;
        end else begin
          span   = TOTAL_UNITS;
          target = 0;
          while (target < LEVELS - 1 && need <= (span >> 1)) begin
            span >>= 1;
            target++;
          end
          if (grab(0, 0, target, 0, TOTAL_UNITS, lo_off)) begin
            blk = 32'(base_address + lo_off);
          end else begin
            st = ST_NO_FIT;
          end
        end
      end else if (longint'(addr) < longint'(base_address) ||
                   longint'(addr) - longint'(base_address) >= TOTAL_UNITS) begin
        st = ST_NOT_ALLOC;
      end else begin
        // Follow the address down to the first full node on its path.
        rel    = longint'(addr) - longint'(base_address);
        n      = 0;
        lo_off = 0;
        span   = TOTAL_UNITS;
        found  = LEVELS;
        for (d = 0; d < LEVELS; d++) begin
          path[d] = n;
          if (node_state[n] == NS_FULL) begin
            found = d;
            break;
          end
          if (d == LEVELS - 1) break;
          span >>= 1;
          if (rel < lo_off + span) begin
            n = 2 * n + 1;
          end else begin
            n = 2 * n + 2;
            lo_off += span;
          end
        end
        if (found == LEVELS) begin
          st = ST_NOT_ALLOC;
        end else begin
          // Empty the block, then merge buddies on the way back up.
          node_state[path[found]] = NS_EMPTY;
          for (d = found; d > 0; d--) begin
            p = path[d-1];
            if (node_state[p] == NS_ALLFULL) node_state[p] = NS_SPLIT;
            if (node_state[2*p+1] == NS_EMPTY && node_state[2*p+2] == NS_EMPTY)
              node_state[p] = NS_EMPTY;
          end
        end
      end
      case (st)
        ST_DONE:   if (cmd == CMD_ALLOC) granted++; else released++;
        ST_NO_FIT: no_fit++;
        default:   refused++;
      endcase
      status_q.push_back(st);
      block_q.push_back(blk);
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(logic [1:0] st, logic [31:0] blk);
      status_t     want_st;
      logic [31:0] want_blk;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d block_address %h", $time, st, blk);
        return;
      end
      want_st  = status_q.pop_front();
      want_blk = block_q.pop_front();
      checked++;
      if (st !== want_st) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want_st, st);
      end
      if (blk !== want_blk) begin
        errors++;
        $display("%0t: block_address mismatch, expected %h, actual %h",
                 $time, want_blk, blk);
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Picks a random allocated block and returns its offset and size.
    function bit pick_block(output longint unsigned lo_off, output longint unsigned span);
      int unsigned full_nodes[$];
      int unsigned n;
      int unsigned d;
      foreach (node_state[i]) if (node_state[i] == NS_FULL) full_nodes.push_back(i);
      if (full_nodes.size() == 0) return 1'b0;
      n = full_nodes[$urandom_range(0, full_nodes.size() - 1)];
      d = 0;
      while ((1 << (d + 1)) - 1 <= n) d++;
      span   = TOTAL_UNITS >> d;
      lo_off = (n - ((1 << d) - 1)) * span;
      return 1'b1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = CMD_ALLOC;
  logic [15:0] request_size = '0;
  logic [31:0] free_address = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] block_address;

  alloc_scoreboard sb = new();
  int burst_left = 0;
  int stall_cycles = 0;
  int n_commands = 0;

  buddy_tree_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .request_size  (request_size),
    .free_address  (free_address),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .status        (status),
    .block_address (block_address)
  );

  always #5 clk = ~clk;

  // Result monitor: every strobed result is checked in order.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(status, block_address);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one command after a random gap and waits until it is taken.
  task automatic issue(cmd_t cmd, logic [15:0] size, logic [31:0] addr);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    request_size <= size;
    free_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd, size, addr);
    n_commands++;
  endtask

  task automatic alloc_units(logic [15:0] size);
    issue(CMD_ALLOC, size, $urandom());
  endtask

  task automatic free_at(logic [31:0] addr);
    issue(CMD_FREE, 16'($urandom()), addr);
  endtask

  // Stops issuing and waits until every expected result has come back.
  task automatic drain(int settle);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    drain(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_base(value);
  endtask

  initial begin
    logic [31:0]     b;
    logic [31:0]     addr;
    logic [15:0]     size;
    longint unsigned lo_off;
    longint unsigned span;
    int              pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed commands: size extremes, out-of-region and unallocated frees,
    // a full tree with a failing search, frees inside blocks and merging.
    b = 32'h0000_1000;
    write_base(b);
    alloc_units(16'd0);
    free_at(b);
    alloc_units(16'd64);
    alloc_units(16'd1);
    free_at(b + 37);
    alloc_units(16'd65);
    alloc_units(16'hFFFF);
    free_at(b - 1);
    free_at(b + 64);
    free_at(b);
    alloc_units(16'd8);
    alloc_units(16'd9);
    alloc_units(16'd32);
    alloc_units(16'd8);
    alloc_units(16'd8);
    free_at(b + 20);
    alloc_units(16'd1);
    free_at(b + 8);
    free_at(b);
    free_at(b + 37);
    free_at(b + 16);
    free_at(32'hFFFF_FFFF);

    // Random phases, each with its own region base, extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_base(32'h0000_0000);
        1:       write_base(32'hFFFF_FFE0);
        3:       write_base(32'hFFFF_FFFF);
        4:       write_base(32'h8000_0000);
        default: write_base($urandom());
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          case ($urandom_range(0, 9))
            0:       size = 16'($urandom());
            1:       size = 16'(MIN_BLOCK << $urandom_range(0, LEVELS - 1));
            2:       size = 16'(TOTAL_UNITS + $urandom_range(0, 3));
            default: size = 16'($urandom_range(0, TOTAL_UNITS));
          endcase
          alloc_units(size);
        end else if (pick < 18 && sb.pick_block(lo_off, span)) begin
          // Free a live block, either at its start or somewhere inside it.
          addr = sb.base_address + 32'(lo_off);
          if ($urandom_range(0, 1) == 1) addr = addr + $urandom_range(0, 32'(span) - 1);
          free_at(addr);
        end else begin
          // Noise: frees outside the region or of whatever the address hits.
          case ($urandom_range(0, 3))
            0:       addr = $urandom();
            1:       addr = sb.base_address - $urandom_range(1, 4);
            2:       addr = sb.base_address + TOTAL_UNITS + $urandom_range(0, 4);
            default: addr = sb.base_address + $urandom_range(0, TOTAL_UNITS - 1);
          endcase
          free_at(addr);
        end
      end
    end

    drain(20);
    $display("Ran %0d commands over %0d region bases: %0d blocks granted, %0d no-fit.",
             n_commands, PHASES + 1, sb.granted, sb.no_fit);
    $display("%0d blocks released, %0d frees refused, %0d results checked.",
             sb.released, sb.refused, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
